>>> rtl/cmr_pkg.sv
// Shared types, constants and the frame classifier for the module registry.
`default_nettype none
package cmr_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int MID_W       = 4;
   localparam int SLOT_W      = 4;
   localparam int ECNT_W      = 5;
   localparam int ID_W        = 11;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;

   localparam logic [ID_W-1:0] ID_UNASSIGNED = 11'h0F0;
   localparam logic [ID_W-1:0] ID_VOLT_ABOVE = 11'h099;
   localparam logic [ID_W-1:0] ID_TEMP_BASE  = 11'h180;
   localparam logic [ID_W-1:0] ID_TEMP_MASK  = 11'h7F0;

   typedef enum logic [1:0] {
      FUNC_FRAME     = 2'd0,
      FUNC_CLEAR_BUS = 2'd1,
      FUNC_CLEAR_ALL = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      CLASS_NONE = 2'd0,
      CLASS_UNAS = 2'd1,
      CLASS_VOLT = 2'd2,
      CLASS_TEMP = 2'd3
   } class_type;

   typedef struct packed {
      logic             bus;
      logic [MID_W-1:0] mid;
   } entry_type;

   // control fanned out from the sequencer to every cell
   typedef struct packed {
      logic             load_find;
      logic             load_keep;
      logic             shift;
      logic             sort_en;
      logic             sort_phase;
      logic             write_en;
      entry_type        key;
      logic [CNT_W-1:0] count;
   } cell_ctrl_type;

   typedef struct packed {
      logic [ECNT_W-1:0] entry_count;
      logic              dropped_full;
      logic              newly_added;
      logic              slot_valid;
      logic [SLOT_W-1:0] slot;
      class_type         frame_class;
   } result_type;

   function automatic class_type classify(input logic [ID_W-1:0] id);
      class_type cls;
      if (id == ID_UNASSIGNED) begin
         cls = CLASS_UNAS;
      end else if (id > ID_VOLT_ABOVE && id < ID_TEMP_BASE) begin
         cls = CLASS_VOLT;
      end else if ((id & ID_TEMP_MASK) == ID_TEMP_BASE) begin
         cls = CLASS_TEMP;
      end else begin
         cls = CLASS_NONE;
      end
      return cls;
   endfunction

endpackage
`default_nettype wire

>>> rtl/cmr_cell.sv
// One table slot: holds an entry, a hole mark and a scan bit, trades with its neighbours.
`default_nettype none
module cmr_cell
   import cmr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [IDX_W-1:0] index,
   input  wire cell_ctrl_type   ctrl,
   input  wire entry_type       right_entry,
   input  wire logic            right_hole,
   input  wire logic            right_scan,
   input  wire entry_type       left_entry,
   input  wire logic            left_hole,
   output entry_type            entry,
   output logic                 hole,
   output logic                 scan
);

   entry_type entry_ff, entry_in;
   logic      hole_ff, hole_in;
   logic      scan_ff, scan_in;
   logic      in_use;

   assign in_use = CNT_W'(index) < ctrl.count;

   always_comb begin
      entry_in = entry_ff;
      hole_in  = hole_ff;
      scan_in  = scan_ff;
      if (ctrl.load_find) begin
         scan_in = in_use && entry_ff.bus == ctrl.key.bus && entry_ff.mid == ctrl.key.mid;
      end
      if (ctrl.load_keep) begin
         hole_in = !(in_use && entry_ff.bus != ctrl.key.bus);
         scan_in = in_use && entry_ff.bus != ctrl.key.bus;
      end
      if (ctrl.shift) begin
         scan_in = right_scan;
      end
      // odd-even transposition: push holes towards the tail, survivors keep order
      if (ctrl.sort_en) begin
         if (index[0] == ctrl.sort_phase) begin
            if (hole_ff && !right_hole) begin
               entry_in = right_entry;
               hole_in  = 1'b0;
            end
         end else if (left_hole && !hole_ff) begin
            entry_in = left_entry;
            hole_in  = 1'b1;
         end
      end
      if (ctrl.write_en && index == ctrl.count[IDX_W-1:0]) begin
         entry_in = ctrl.key;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         hole_ff <= 1'b0;
         scan_ff <= 1'b0;
      end else begin
         hole_ff <= hole_in;
         scan_ff <= scan_in;
      end
   end

   assign entry = entry_ff;
   assign hole  = hole_ff;
   assign scan  = scan_ff;

endmodule
`default_nettype wire

>>> rtl/can_module_registry_core.sv
// Top level of the module registry: request decode, sequencer and the chain of slot cells.
// Sequence: a lookup steps through S_FIND until a hit or the last slot (a hit ends the scan early),
//   a bus clear steps through S_CLEAR over every slot, and other beats go straight to S_EMIT;
//   S_EMIT then registers the result into the output stage. A new beat is accepted only in S_IDLE.
//   Scan bits step through the cell chain one slot a cycle; a bus clear also runs the transposition rounds.
// Reset: synchronous, active high; empties the table (count zero) and the output stage;
//   slot contents stay undefined and are never read before being written.
`default_nettype none
module can_module_registry_core
   import cmr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [1:0] func, [2] bus, [13:3] frame_id, [15:14] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [1:0] frame_class, [5:2] slot, [6] slot_valid, [7] newly_added,
   // [8] dropped_full, [13:9] entry_count, [15:14] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_CLEAR,
      S_EMIT
   } state_type;

   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL      = CNT_W'(TABLE_DEPTH);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]      keep_ff, keep_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   entry_type             key_ff, key_in;
   result_type            res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   cell_ctrl_type ctrl;
   logic          req_fire;
   logic [1:0]    req_func;
   logic          req_bus;
   logic [ID_W-1:0] req_id;
   class_type     req_class;
   entry_type     req_key;
   logic [CNT_W-1:0] keep_sum;

   entry_type cell_entry [TABLE_DEPTH];
   logic      cell_hole  [TABLE_DEPTH];
   logic      cell_scan  [TABLE_DEPTH];

   // unpack the request beat
   assign req_func  = req_tdata[1:0];
   assign req_bus   = req_tdata[2];
   assign req_id    = req_tdata[13:3];
   assign req_class = classify(req_id);
   assign req_key   = '{bus: req_bus, mid: req_id[MID_W-1:0]};

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign keep_sum   = keep_ff + CNT_W'(cell_scan[0]);

   // cell chain: scan bits advance towards slot 0, holes bubble towards the tail
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      entry_type r_entry, l_entry;
      logic      r_hole, r_scan, l_hole;

      if (g == TABLE_DEPTH - 1) begin : g_tail
         assign r_entry = '0;
         assign r_hole  = 1'b1;
         assign r_scan  = 1'b0;
      end else begin : g_mid
         assign r_entry = cell_entry[g+1];
         assign r_hole  = cell_hole[g+1];
         assign r_scan  = cell_scan[g+1];
      end

      if (g == 0) begin : g_head
         assign l_entry = '0;
         assign l_hole  = 1'b0;
      end else begin : g_rest
         assign l_entry = cell_entry[g-1];
         assign l_hole  = cell_hole[g-1];
      end

      cmr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .index       (IDX_W'(g)),
         .ctrl        (ctrl),
         .right_entry (r_entry),
         .right_hole  (r_hole),
         .right_scan  (r_scan),
         .left_entry  (l_entry),
         .left_hole   (l_hole),
         .entry       (cell_entry[g]),
         .hole        (cell_hole[g]),
         .scan        (cell_scan[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      keep_in      = keep_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      ctrl            = '0;
      ctrl.count      = count_ff;
      ctrl.key        = (state_ff == S_IDLE) ? req_key : key_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               step_in            = '0;
               keep_in            = '0;
               key_in             = req_key;
               res_in             = '0;
               res_in.frame_class = CLASS_NONE;
               res_in.entry_count = ECNT_W'(count_ff);
               case (req_func)
                  FUNC_FRAME: begin
                     res_in.frame_class = req_class;
                     if (req_class == CLASS_VOLT || req_class == CLASS_TEMP) begin
                        ctrl.load_find = 1'b1;
                        state_in       = S_FIND;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
                  FUNC_CLEAR_BUS: begin
                     ctrl.load_keep = 1'b1;
                     state_in       = S_CLEAR;
                  end
                  FUNC_CLEAR_ALL: begin
                     count_in           = '0;
                     res_in.entry_count = '0;
                     state_in           = S_EMIT;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_FIND: begin
            // slot step_ff sits at the head of the chain this cycle
            ctrl.shift = 1'b1;
            step_in    = step_ff + 1'b1;
            if (cell_scan[0]) begin
               res_in.slot       = SLOT_W'(step_ff);
               res_in.slot_valid = 1'b1;
               state_in          = S_EMIT;
            end else if (step_ff == LAST_STEP) begin
               if (count_ff == FULL) begin
                  res_in.dropped_full = 1'b1;
               end else begin
                  // append at the first free slot
                  ctrl.write_en      = 1'b1;
                  res_in.slot        = SLOT_W'(count_ff);
                  res_in.slot_valid  = 1'b1;
                  res_in.newly_added = 1'b1;
                  count_in           = count_ff + 1'b1;
                  res_in.entry_count = ECNT_W'(count_ff + 1'b1);
               end
               state_in = S_EMIT;
            end
         end
         S_CLEAR: begin
            // count survivors off the head while the transposition rounds compact them
            ctrl.shift      = 1'b1;
            ctrl.sort_en    = 1'b1;
            ctrl.sort_phase = step_ff[0];
            keep_in         = keep_sum;
            step_in         = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               count_in           = keep_sum;
               res_in.entry_count = ECNT_W'(keep_sum);
               state_in           = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold the result until the output stage is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_ff.entry_count, res_ff.dropped_full,
                                           res_ff.newly_added, res_ff.slot_valid,
                                           res_ff.slot, res_ff.frame_class});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      keep_ff     <= keep_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the table never holds more entries than it has slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("entry count beyond table depth");

   // a hit can only come from an occupied slot
   a_hit_in_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND && cell_scan[0]) |-> (CNT_W'(step_ff) < count_ff))
      else $error("lookup hit on an unoccupied slot");

   // a bus clear never grows the table
   a_clear_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && step_ff == LAST_STEP) |=> count_ff <= $past(count_ff))
      else $error("bus clear increased the entry count");

   // a result cannot both append and drop
   a_add_xor_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[7] && rsp_data_ff[8]))
      else $error("result both added and dropped");

   // an accepted beat always starts work
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("accepted beat left the sequencer idle");

endmodule
`default_nettype wire
